@@ sv/mode_ac_reply_classifier_core_macros.svh @@
// Assertion helpers shared by the classifier RTL.
`ifndef MODE_AC_REPLY_CLASSIFIER_CORE_MACROS_SVH
`define MODE_AC_REPLY_CLASSIFIER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MACR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/macr_pkg.sv @@
package macr_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 8;
  localparam int SLOT_BITS = 12;
  localparam int TABLE_DEPTH = 4096;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MODE_A = 2'd1;
  localparam logic [1:0] KIND_MODE_C = 2'd2;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MIN_COUNT = 2'd1;
  localparam logic [1:0] REG_ALT_LOW = 2'd2;
  localparam logic [1:0] REG_ALT_HIGH = 2'd3;

  localparam logic [15:0] CODE_MASK = 16'h7777;
  localparam logic [15:0] SPI_BIT = 16'h0080;
  localparam logic [15:0] EMERG_HIJACK = 16'h7500;
  localparam logic [15:0] EMERG_RADIO = 16'h7600;
  localparam logic [15:0] EMERG_GENERAL = 16'h7700;
  localparam logic [15:0] GILLHAM_BAD = 16'h8889;
  localparam logic [15:0] GILLHAM_C = 16'h00F0;
  localparam logic [11:0] ALT_OFFSET = 12'd13;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_COMMIT
  } state_t;

  // Gillham decode; bit 12 of the result is the invalid flag, bits 11:0
  // hold (hundreds + 13), never negative for a valid code.
  function automatic logic [12:0] gillham(input logic [15:0] m);
    logic [2:0] ones;
    logic [7:0] fives;
    logic bad;
    logic [11:0] sum;
    ones = 3'd0;
    fives = 8'd0;
    bad = ((m & GILLHAM_BAD) != 16'd0) || ((m & GILLHAM_C) == 16'd0);
    if (m[4]) ones = ones ^ 3'd7;
    if (m[5]) ones = ones ^ 3'd3;
    if (m[6]) ones = ones ^ 3'd1;
    if ((ones & 3'd5) == 3'd5) ones = ones ^ 3'd2;
    if (ones > 3'd5) bad = 1'b1;
    if (m[1]) fives = fives ^ 8'hFF;
    if (m[2]) fives = fives ^ 8'h7F;
    if (m[12]) fives = fives ^ 8'h3F;
    if (m[13]) fives = fives ^ 8'h1F;
    if (m[14]) fives = fives ^ 8'h0F;
    if (m[8]) fives = fives ^ 8'h07;
    if (m[9]) fives = fives ^ 8'h03;
    if (m[10]) fives = fives ^ 8'h01;
    if (fives[0]) ones = 3'd6 - ones;
    sum = {2'b00, fives, 2'b00} + {4'd0, fives} + {9'd0, ones};
    return {bad, sum};
  endfunction

endpackage

@@ sv/macr_ram.sv @@
module macr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mode_ac_reply_classifier_core.sv @@
// Mode A/C reply classifier. Each input beat is either a one-second tick
// (operation = 1, no result) or a pair of raw reply bytes, which yields
// exactly one result beat: kind, squawk, SPI flag and altitude in feet.
// Per-code statistics live in two synchronous RAMs (one for the identity
// table, one for the altitude-candidate table), each entry holding a
// present flag, last-period count and current count. A reply is taken,
// then its table entries are read, then the block decides, writes back
// and registers the result; the next beat can be taken right after the
// write-back. When a reply arrives more than stat_interval_seconds ticks
// after the previous commit, the block first walks all 4096 entries, one
// per cycle, moving current counts to last counts before that reply is
// classified. After reset the same walk clears both tables, and no beat
// is taken until that walk ends. A finished result sits in an output
// register; a new input beat is taken while it waits, but its result must
// drain before the next reply is classified.
`include "mode_ac_reply_classifier_core_macros.svh"

module mode_ac_reply_classifier_core #(
  parameter int COUNT_WIDTH = macr_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // first_byte, second_byte
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // reply_kind, squawk, spi_flag, altitude_feet
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int SB = macr_pkg::SLOT_BITS;
  localparam int EW = 2 * COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [7:0]  stat_interval;
  logic [7:0]  min_count;
  logic [10:0] alt_low;
  logic [10:0] alt_high;
  logic [7:0]  seconds;

  macr_pkg::state_t state, state_next;
  logic [SB:0] sweep;          // walk counter, top bit marks the end
  logic        clearing;       // walk is the reset clear, not a commit
  logic [15:0] m_code;         // reordered pulse bits of the held reply
  logic        rejected;
  logic        hold_valid;     // a reply beat is waiting to be classified

  // Entry packing: {present, last, now}.
  logic          a_we, n_we;
  logic [SB-1:0] waddr, raddr;
  logic [EW-1:0] a_wdata, n_wdata, a_rdata, n_rdata;

  macr_ram #(.WIDTH(EW), .DEPTH(macr_pkg::TABLE_DEPTH)) u_a_ram (
    .clk, .we(a_we), .waddr, .wdata(a_wdata), .raddr, .rdata(a_rdata));
  macr_ram #(.WIDTH(EW), .DEPTH(macr_pkg::TABLE_DEPTH)) u_n_ram (
    .clk, .we(n_we), .waddr, .wdata(n_wdata), .raddr, .rdata(n_rdata));

  logic [7:0] b0, b1;
  assign b0 = s_axis_tdata[7:0];
  assign b1 = s_axis_tdata[15:8];

  logic [15:0] m_in;
  assign m_in = {1'b0, b1[7], b0[1], b0[3], 1'b0, b1[1], b1[3], b1[5],
                 b0[7], b0[0], b0[2], b0[4], 1'b0, b1[0], b1[2], b1[4]};

  function automatic logic [SB-1:0] slot_of(input logic [15:0] m);
    return {m[14:12], m[10:8], m[6:4], m[2:0]};
  endfunction

  logic in_fire, out_fire, commit_due;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign commit_due = seconds > stat_interval;
  assign cfg_ready = 1'b1;

  // The input is taken in IDLE when no reply is held.
  assign s_axis_tready = (state == macr_pkg::ST_IDLE) && !hold_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      macr_pkg::ST_CLEAR:  if (sweep[SB]) state_next = macr_pkg::ST_IDLE;
      macr_pkg::ST_COMMIT: if (sweep[SB]) state_next = macr_pkg::ST_IDLE;
      macr_pkg::ST_IDLE: begin
        if (hold_valid && commit_due) state_next = macr_pkg::ST_COMMIT;
        else if (hold_valid && !m_axis_tvalid) state_next = macr_pkg::ST_UPDATE;
      end
      macr_pkg::ST_UPDATE: state_next = macr_pkg::ST_IDLE;
      default: state_next = macr_pkg::ST_IDLE;
    endcase
  end

  // Decision on the entries read for the held reply.
  logic          a_pres, n_pres;
  logic [COUNT_WIDTH-1:0] a_last, a_now, n_last, n_now;
  assign {a_pres, a_last, a_now} = a_rdata;
  assign {n_pres, n_last, n_now} = n_rdata;

  logic [15:0] code;
  logic [2:0]  c_dig, d_dig;
  logic [12:0] gil;
  logic [11:0] hpl;            // hundreds + 13
  logic [1:0]  kind;
  logic        bump_a, bump_n, in_window, trusted;
  logic [COUNT_WIDTH:0] min_ext;

  assign code = m_code & macr_pkg::CODE_MASK;
  assign c_dig = m_code[6:4];
  assign d_dig = m_code[2:0];
  assign gil = macr_pkg::gillham(m_code);
  assign hpl = gil[11:0];
  // Compare with the config widened to the count width or beyond.
  assign min_ext = (COUNT_WIDTH >= 8) ? (COUNT_WIDTH+1)'(min_count)
                   : ((min_count > 8'(CMAX)) ? (COUNT_WIDTH+1)'({1'b1, CMAX})
                                              : (COUNT_WIDTH+1)'(min_count));
  assign in_window = !gil[12] && hpl >= 12'(alt_low) + macr_pkg::ALT_OFFSET
                     && hpl <= 12'(alt_high) + macr_pkg::ALT_OFFSET;
  assign trusted = n_pres && ({1'b0, n_last} > min_ext);

  always_comb begin
    kind = macr_pkg::KIND_NONE;
    bump_a = 1'b0;
    bump_n = 1'b0;
    if (rejected) begin
      kind = macr_pkg::KIND_NONE;
    end else if ((m_code & macr_pkg::SPI_BIT) != 16'd0 ||
                 code == macr_pkg::EMERG_HIJACK || code == macr_pkg::EMERG_RADIO ||
                 code == macr_pkg::EMERG_GENERAL) begin
      kind = macr_pkg::KIND_MODE_A;
    end else if (c_dig == 3'd0 || c_dig == 3'd5 || c_dig == 3'd7 ||
                 (d_dig != 3'd0 && d_dig != 3'd4)) begin
      bump_a = 1'b1;
      kind = (!a_pres || ({1'b0, a_last} > min_ext)) ? macr_pkg::KIND_MODE_A
                                                     : macr_pkg::KIND_NONE;
    end else if (trusted) begin
      if (in_window) begin
        kind = macr_pkg::KIND_MODE_C;
      end else begin
        bump_a = 1'b1;
        kind = macr_pkg::KIND_MODE_A;
      end
    end else begin
      bump_n = 1'b1;
    end
  end

  function automatic logic [EW-1:0] bumped(input logic [EW-1:0] e);
    logic [COUNT_WIDTH-1:0] nw;
    nw = e[COUNT_WIDTH-1:0];
    if (!e[EW-1]) nw = COUNT_WIDTH'(1);
    else if (nw != CMAX) nw = nw + COUNT_WIDTH'(1);
    return {1'b1, e[EW-2:COUNT_WIDTH], nw};
  endfunction

  // RAM control. A walk reads entry sweep and writes back the entry that
  // the previous sweep value read, so it finishes when sweep reaches 4096.
  logic in_walk;
  assign in_walk = (state == macr_pkg::ST_CLEAR) || (state == macr_pkg::ST_COMMIT);

  always_comb begin
    raddr = slot_of(m_code);
    waddr = slot_of(m_code);
    a_we = 1'b0;
    n_we = 1'b0;
    a_wdata = bumped(a_rdata);
    n_wdata = bumped(n_rdata);
    if (in_walk) begin
      raddr = sweep[SB-1:0];
      waddr = sweep[SB-1:0] - SB'(1);
      a_we = (sweep != '0);
      n_we = a_we;
      if (clearing) begin
        a_wdata = '0;
        n_wdata = '0;
      end else begin
        a_wdata = {a_pres, a_now, {COUNT_WIDTH{1'b0}}};
        n_wdata = {n_pres, n_now, {COUNT_WIDTH{1'b0}}};
      end
    end else if (state == macr_pkg::ST_UPDATE) begin
      a_we = bump_a;
      n_we = bump_n;
    end
  end

  // Sweep counter starts at zero on entering a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= macr_pkg::ST_CLEAR;
      sweep <= '0;
      clearing <= 1'b1;
      hold_valid <= 1'b0;
      seconds <= '0;
      m_axis_tvalid <= 1'b0;
      stat_interval <= 8'd10;
      min_count <= 8'd3;
      alt_low <= 11'd167;
      alt_high <= 11'd489;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          macr_pkg::REG_INTERVAL:  stat_interval <= cfg_data[7:0];
          macr_pkg::REG_MIN_COUNT: min_count <= cfg_data[7:0];
          macr_pkg::REG_ALT_LOW:   alt_low <= cfg_data;
          macr_pkg::REG_ALT_HIGH:  alt_high <= cfg_data;
          default: ;
        endcase
      end
      if (in_walk) begin
        sweep <= sweep + (SB+1)'(1);
      end else begin
        sweep <= '0;
      end
      if (state == macr_pkg::ST_CLEAR && sweep[SB]) clearing <= 1'b0;
      if (state == macr_pkg::ST_COMMIT) seconds <= '0;
      if (in_fire) begin
        if (s_axis_tuser) begin
          if (seconds != 8'hFF) seconds <= seconds + 8'd1;
        end else begin
          hold_valid <= 1'b1;
        end
      end
      if (state == macr_pkg::ST_UPDATE) hold_valid <= 1'b0;
      if (state == macr_pkg::ST_UPDATE) m_axis_tvalid <= 1'b1;
      else if (out_fire) m_axis_tvalid <= 1'b0;
    end
  end

  logic [1:0]  out_kind;
  logic [14:0] out_squawk;
  logic        out_spi;
  logic [16:0] out_alt;

  always_ff @(posedge clk) begin
    if (in_fire && !s_axis_tuser) begin
      m_code <= m_in;
      rejected <= (s_axis_tdata == 16'd0) || b1[6];
    end
    if (state == macr_pkg::ST_UPDATE) begin
      out_kind <= kind;
      out_squawk <= (kind == macr_pkg::KIND_MODE_A) ? code[14:0] : 15'd0;
      out_spi <= (kind == macr_pkg::KIND_MODE_A) && m_code[7];
      out_alt <= (kind == macr_pkg::KIND_MODE_C)
                 ? 17'(({5'd0, hpl} - 17'd13) * 17'd100) : 17'd0;
    end
  end

  assign m_axis_tdata = {5'd0, out_alt, out_spi, out_squawk, out_kind};

  `MACR_ASSERT_IMP(a_no_take_in_walk, clk, rst, in_walk, !s_axis_tready,
    "input taken during table walk")
  `MACR_ASSERT_NEXT(a_update_gives_result, clk, rst,
    state == macr_pkg::ST_UPDATE, m_axis_tvalid, "update produced no result")
  `MACR_ASSERT_IMP(a_one_table_bump, clk, rst, state == macr_pkg::ST_UPDATE,
    !(a_we && n_we), "both tables bumped by one reply")

endmodule
